// ===== src/lrcc_pkg.sv =====
// ============================================================================
// lrcc_pkg: shared types and constants for the lane run centroid classifier
// Register map indexes, lane side codes, register reset values.
// ============================================================================
`default_nettype none

package lrcc_pkg;

  // Configuration port
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_LEFT_BOUNDARY   = 2'd0;
  localparam logic [1:0] REG_CENTER_BOUNDARY = 2'd1;
  localparam logic [1:0] REG_RIGHT_RUN_LIMIT = 2'd2;

  // Register reset values
  localparam int LEFT_BOUNDARY_RST   = 115;
  localparam int CENTER_BOUNDARY_RST = 320;
  localparam int RIGHT_RUN_LIMIT_RST = 80;

  // Lane side codes
  localparam logic [1:0] SIDE_LEFT   = 2'd0;
  localparam logic [1:0] SIDE_CENTER = 2'd1;
  localparam logic [1:0] SIDE_RIGHT  = 2'd2;

  // Verdict on one finished run
  typedef struct packed {
    logic       keep;
    logic [1:0] side;
  } run_class_t;

endpackage

`default_nettype wire

// ===== src/lane_run_centroid_classifier_core.sv =====
// ============================================================================
// lane_run_centroid_classifier_core: lane marking run detector, top level
// Input beat register, run tracker, result register and APB register file.
// ============================================================================
// Flow: a pixel beat is captured in the input register and classified as it
//   leaves it; a reported marking lands in the result register (out_tvalid).
// Throughput: one pixel per cycle unless the output side stalls; the open-run
//   update is a single compare and increment, done in the cycle the beat
//   leaves the input register.
// Reset (rst_n low, synchronous): both stages empty, no run open, registers
//   back to left_boundary 115, center_boundary 320, right_run_limit 80.
`default_nettype none

module lane_run_centroid_classifier_core
  import lrcc_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // pixel stream
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // [COORD_BITS-1:0] column, [2*COORD_BITS-1:COORD_BITS] row, zero pad above
  input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]     in_tdata,
  // [0] pixel_set
  input  wire logic                                  in_tuser,
  input  wire logic                                  in_tlast,      // row_end
  // marking stream
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // [COORD_BITS-1:0] mark_column, [2*COORD_BITS-1:COORD_BITS] mark_row, zero pad
  output logic      [((2*COORD_BITS+7)/8)*8-1:0]     out_tdata,
  // [1:0] lane_side
  output logic      [1:0]                            out_tuser,
  // configuration
  input  wire logic                                  cfg_psel,
  input  wire logic                                  cfg_penable,
  input  wire logic                                  cfg_pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0]              cfg_paddr,
  input  wire logic [CFG_DATA_BITS-1:0]              cfg_pwdata,
  output logic      [CFG_DATA_BITS-1:0]              cfg_prdata,
  output logic                                       cfg_pready
);

  localparam int DATA_BITS = ((2*COORD_BITS+7)/8)*8;

  // ---------------------------------------------------------------------------
  // Register file
  // ---------------------------------------------------------------------------
  logic [COORD_BITS-1:0] left_boundary_r;
  logic [COORD_BITS-1:0] center_boundary_r;
  logic [COORD_BITS:0]   right_run_limit_r;
  logic                  cfg_wr;
  logic [1:0]            cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_boundary_r   <= COORD_BITS'(LEFT_BOUNDARY_RST);
      center_boundary_r <= COORD_BITS'(CENTER_BOUNDARY_RST);
      right_run_limit_r <= (COORD_BITS+1)'(RIGHT_RUN_LIMIT_RST);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LEFT_BOUNDARY:   left_boundary_r   <= cfg_pwdata[COORD_BITS-1:0];
        REG_CENTER_BOUNDARY: center_boundary_r <= cfg_pwdata[COORD_BITS-1:0];
        REG_RIGHT_RUN_LIMIT: right_run_limit_r <= cfg_pwdata[COORD_BITS:0];
        default: ;  // unmapped: write ignored
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LEFT_BOUNDARY:   cfg_prdata = CFG_DATA_BITS'(left_boundary_r);
      REG_CENTER_BOUNDARY: cfg_prdata = CFG_DATA_BITS'(center_boundary_r);
      REG_RIGHT_RUN_LIMIT: cfg_prdata = CFG_DATA_BITS'(right_run_limit_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input beat register. It drains whenever the result register has room,
  // so a new beat is taken every cycle unless the output side stalls.
  // ---------------------------------------------------------------------------
  logic                  s1_valid_r;
  logic                  s1_set_r;
  logic [COORD_BITS-1:0] s1_column_r;
  logic [COORD_BITS-1:0] s1_row_r;
  logic                  s1_end_r;
  logic                  s1_fire;
  logic                  in_fire;

  logic                  out_valid_r;
  logic [COORD_BITS-1:0] mark_column_r;
  logic [COORD_BITS-1:0] mark_row_r;
  logic [1:0]            lane_side_r;

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_set_r    <= in_tuser;
      s1_column_r <= in_tdata[COORD_BITS-1:0];
      s1_row_r    <= in_tdata[2*COORD_BITS-1:COORD_BITS];
      s1_end_r    <= in_tlast;
    end
  end

  // ---------------------------------------------------------------------------
  // Run tracking and classification
  // ---------------------------------------------------------------------------
  logic                  emit;
  logic [COORD_BITS-1:0] mark_column;
  logic [COORD_BITS-1:0] mark_row;
  logic [1:0]            lane_side;

  lrcc_run_tracker #(.COORD_BITS(COORD_BITS)) u_tracker (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (s1_fire),
    .pixel_set       (s1_set_r),
    .column          (s1_column_r),
    .row             (s1_row_r),
    .row_end         (s1_end_r),
    .left_boundary   (left_boundary_r),
    .center_boundary (center_boundary_r),
    .right_run_limit (right_run_limit_r),
    .emit            (emit),
    .mark_column     (mark_column),
    .mark_row        (mark_row),
    .lane_side       (lane_side)
  );

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      mark_column_r <= mark_column;
      mark_row_r    <= mark_row;
      lane_side_r   <= lane_side;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_BITS'({mark_row_r, mark_column_r});
  assign out_tuser  = lane_side_r;

endmodule

`default_nettype wire

// ===== src/lrcc_classifier.sv =====
// ============================================================================
// lrcc_classifier: classify one finished run
// Mean column, run length, side decision and the right-run length filter.
// ============================================================================
`default_nettype none

module lrcc_classifier
  import lrcc_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  wire logic [COORD_BITS-1:0] first,
  input  wire logic [COORD_BITS-1:0] last,
  input  wire logic [COORD_BITS-1:0] left_boundary,
  input  wire logic [COORD_BITS-1:0] center_boundary,
  input  wire logic [COORD_BITS:0]   right_run_limit,
  output logic      [COORD_BITS-1:0] mean,
  output run_class_t                 verdict
);

  logic [COORD_BITS:0] sum;
  logic [COORD_BITS:0] run_len;

  assign sum  = {1'b0, first} + {1'b0, last};
  assign mean = sum[COORD_BITS:1];

  always_comb begin
    if (last >= first) begin
      run_len = {1'b0, last} - {1'b0, first} + (COORD_BITS+1)'(1);
    end else begin
      run_len = (COORD_BITS+1)'(1);
    end
  end

  always_comb begin
    if (mean < left_boundary) begin
      verdict.side = SIDE_LEFT;
      verdict.keep = 1'b1;
    end else if ((mean > left_boundary) && (mean < center_boundary)) begin
      verdict.side = SIDE_CENTER;
      verdict.keep = 1'b1;
    end else begin
      // mean equal to the left boundary lands here as well
      verdict.side = SIDE_RIGHT;
      verdict.keep = (run_len < right_run_limit);
    end
  end

endmodule

`default_nettype wire

// ===== src/lrcc_run_tracker.sv =====
// ============================================================================
// lrcc_run_tracker: open-run state and result selection
// Tracks the run in progress and picks the run that finishes on each beat.
// ============================================================================
`default_nettype none

module lrcc_run_tracker
  import lrcc_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire logic                  pixel_set,
  input  wire logic [COORD_BITS-1:0] column,
  input  wire logic [COORD_BITS-1:0] row,
  input  wire logic                  row_end,
  input  wire logic [COORD_BITS-1:0] left_boundary,
  input  wire logic [COORD_BITS-1:0] center_boundary,
  input  wire logic [COORD_BITS:0]   right_run_limit,
  output logic                       emit,
  output logic      [COORD_BITS-1:0] mark_column,
  output logic      [COORD_BITS-1:0] mark_row,
  output logic      [1:0]            lane_side
);

  logic                  run_open_r;
  logic [COORD_BITS-1:0] run_first_r, run_first_nxt;
  logic [COORD_BITS-1:0] run_last_r,  run_last_nxt;
  logic [COORD_BITS-1:0] run_row_r,   run_row_nxt;
  logic                  run_open_nxt;

  logic                  extend;
  logic                  old_emit;
  logic                  end_emit;
  logic [COORD_BITS-1:0] old_mean, end_mean;
  logic [COORD_BITS-1:0] end_first, end_row;
  run_class_t            old_verdict, end_verdict;

  // one column past run_last, no wrap to zero
  assign extend = run_open_r && pixel_set && (row == run_row_r) &&
                  ({1'b0, column} == ({1'b0, run_last_r} + (COORD_BITS+1)'(1)));

  // run closed by this beat
  lrcc_classifier #(.COORD_BITS(COORD_BITS)) u_old_cls (
    .first           (run_first_r),
    .last            (run_last_r),
    .left_boundary   (left_boundary),
    .center_boundary (center_boundary),
    .right_run_limit (right_run_limit),
    .mean            (old_mean),
    .verdict         (old_verdict)
  );

  // run that the row end closes, including this pixel
  assign end_first = extend ? run_first_r : column;
  assign end_row   = extend ? run_row_r   : row;

  lrcc_classifier #(.COORD_BITS(COORD_BITS)) u_end_cls (
    .first           (end_first),
    .last            (column),
    .left_boundary   (left_boundary),
    .center_boundary (center_boundary),
    .right_run_limit (right_run_limit),
    .mean            (end_mean),
    .verdict         (end_verdict)
  );

  assign old_emit = run_open_r && !extend && old_verdict.keep;
  // a row-end run is dropped when the older run already reported
  assign end_emit = row_end && pixel_set && !old_emit && end_verdict.keep;
  assign emit     = old_emit || end_emit;

  assign mark_column = old_emit ? old_mean          : end_mean;
  assign mark_row    = old_emit ? run_row_r         : end_row;
  assign lane_side   = old_emit ? old_verdict.side  : end_verdict.side;

  always_comb begin
    run_open_nxt  = run_open_r;
    run_first_nxt = run_first_r;
    run_last_nxt  = run_last_r;
    run_row_nxt   = run_row_r;
    if (step) begin
      run_open_nxt = pixel_set && !row_end;
      if (pixel_set && !row_end) begin
        run_last_nxt = column;
        if (!extend) begin
          run_first_nxt = column;
          run_row_nxt   = row;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_open_r  <= 1'b0;
      run_first_r <= '0;
      run_last_r  <= '0;
      run_row_r   <= '0;
    end else begin
      run_open_r  <= run_open_nxt;
      run_first_r <= run_first_nxt;
      run_last_r  <= run_last_nxt;
      run_row_r   <= run_row_nxt;
    end
  end

  a_row_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    step && row_end |=> !run_open_r)
    else $error("run still open after row end");

  a_extend_advances: assert property (@(posedge clk) disable iff (!rst_n)
    step && extend && !row_end |=> run_last_r == $past(run_last_r) + COORD_BITS'(1))
    else $error("extended run did not advance by one column");

  a_run_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    run_open_r |-> run_first_r <= run_last_r)
    else $error("open run has first column past last column");

endmodule

`default_nettype wire

// ===== test/lane_run_centroid_classifier_core_tb.sv =====
// ============================================================================
// lane_run_centroid_classifier_core_tb: self-checking bench for the run core
// Streams pixel beats through the core under several register settings and
// checks every marking beat against an in-bench run tracker. Directed rows
// cover the boundary cases; random rows, broken rows and noise fill the rest,
// with random idle bursts on one or both streams in every phase but the closing one.
// ============================================================================

module lane_run_centroid_classifier_core_tb;
  import lrcc_pkg::*;

  localparam int CB      = 10;
  localparam int TDW     = ((2*CB+7)/8)*8;
  localparam int LAT_PAD = 8;       // a result passes the input and result registers; pad generously
  localparam int DRAIN_CAP = 20000; // cycles allowed for one phase to drain

  typedef struct packed {
    logic          set;
    logic [CB-1:0] column;
    logic [CB-1:0] row;
    logic          row_end;
  } pixel_t;

  typedef struct packed {
    logic [CB-1:0] column;
    logic [CB-1:0] row;
    logic [1:0]    side;
  } marking_t;

  // ---------------------------------------------------------------- DUT I/O
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [TDW-1:0]           in_tdata = '0;  // [9:0] column, [19:10] row, pad
  logic                     in_tuser = 1'b0; // [0] pixel_set
  logic                     in_tlast = 1'b0; // row_end
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [TDW-1:0]           out_tdata;      // [9:0] mark_column, [19:10] mark_row
  logic [1:0]               out_tuser;      // [1:0] lane_side
  logic                     cfg_psel = 1'b0;
  logic                     cfg_penable = 1'b0;
  logic                     cfg_pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;

  lane_run_centroid_classifier_core #(.COORD_BITS(CB)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ------------------------------------------------------------ bench state
  pixel_t   pix_q[$];        // pixels waiting for the driver
  marking_t marking_q[$];    // markings the core still owes us
  pixel_t   next_pix;
  logic     pix_taken = 1'b0;
  int       in_gap = 0;
  int       out_gap = 0;
  bit       stall_in = 1'b0;
  bit       stall_out = 1'b0;
  logic [CFG_DATA_BITS-1:0] rd_capture = '0;

  // register shadows
  logic [CB-1:0] left_bnd   = CB'(LEFT_BOUNDARY_RST);
  logic [CB-1:0] center_bnd = CB'(CENTER_BOUNDARY_RST);
  logic [CB:0]   run_limit  = (CB+1)'(RIGHT_RUN_LIMIT_RST);

  // open run as the tracker sees it
  bit            trk_open = 1'b0;
  logic [CB-1:0] trk_first = '0;
  logic [CB-1:0] trk_last = '0;
  logic [CB-1:0] trk_row = '0;

  int fails = 0;
  int beats_in = 0;
  int settings = 1;
  int side_seen[3] = '{0, 0, 0};

  // ------------------------------------------------------------ run tracker
  // Verdict for a finished run: returns 1 when a marking is reported.
  function automatic bit classify_run(input logic [CB-1:0] first, input logic [CB-1:0] last,
                                      input logic [CB-1:0] row, output marking_t m);
    logic [CB:0]   sum;
    logic [CB-1:0] mean;
    logic [CB:0]   len;
    sum  = {1'b0, first} + {1'b0, last};
    mean = sum[CB:1];
    len  = (last >= first) ? ({1'b0, last} - {1'b0, first} + 1'b1) : (CB+1)'(1);
    m.column = mean;
    m.row    = row;
    if (mean < left_bnd) begin
      m.side = SIDE_LEFT;
      return 1'b1;
    end
    // mean exactly on the left boundary falls through to the right side
    if (mean > left_bnd && mean < center_bnd) begin
      m.side = SIDE_CENTER;
      return 1'b1;
    end
    m.side = SIDE_RIGHT;
    return len < run_limit;
  endfunction

  function automatic void track_pixel(input pixel_t px);
    bit       extend;
    bit       got;
    marking_t m;
    got = 1'b0;
    // adjacency is checked one bit wider so 1023 -> 0 never continues a run
    extend = trk_open && px.set && px.row == trk_row &&
             {1'b0, px.column} == {1'b0, trk_last} + 1'b1;
    if (trk_open && !extend) begin
      got = classify_run(trk_first, trk_last, trk_row, m);
      trk_open = 1'b0;
    end
    if (px.set) begin
      if (extend) begin
        trk_last = px.column;
      end else if (!px.row_end || !got) begin
        // a fresh run on a row-end pixel survives only if the old run was dropped
        trk_open  = 1'b1;
        trk_first = px.column;
        trk_last  = px.column;
        trk_row   = px.row;
      end
    end
    if (px.row_end && trk_open) begin
      if (!got) got = classify_run(trk_first, trk_last, trk_row, m);
      trk_open = 1'b0;
    end
    if (got) begin
      marking_q.insert(marking_q.size(), m);
      side_seen[m.side]++;
    end
  endfunction

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    marking_t act;
    marking_t exp;
    if (rst_n) begin
      pix_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        track_pixel('{in_tuser, in_tdata[CB-1:0], in_tdata[2*CB-1:CB], in_tlast});
        beats_in++;
      end
      if (cfg_psel && cfg_penable && !cfg_pwrite && cfg_pready) rd_capture <= cfg_prdata;
      if (out_tvalid && out_tready) begin
        act = '{out_tdata[CB-1:0], out_tdata[2*CB-1:CB], out_tuser};
        if (marking_q.size() == 0) begin
          $display("%0t: unexpected marking beat, expected none, got col %0d row %0d side %0d",
                   $time, act.column, act.row, act.side);
          fails++;
        end else begin
          exp = marking_q.pop_front();
          if (act !== exp) begin
            $display("%0t: marking mismatch, expected col %0d row %0d side %0d, got col %0d row %0d side %0d",
                     $time, exp.column, exp.row, exp.side, act.column, act.row, act.side);
            fails++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------- pixel driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !pix_taken) begin
        // beat still pending, hold it
      end else if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap    <= in_gap - 1;
      end else if (pix_q.size() > 0 && stall_in && $urandom_range(0, 7) == 0) begin
        in_tvalid <= 1'b0;
        in_gap    <= $urandom_range(0, 14);
      end else if (pix_q.size() > 0) begin
        next_pix  = pix_q.pop_front();
        in_tdata  <= {{(TDW-2*CB){1'b0}}, next_pix.row, next_pix.column};
        in_tuser  <= next_pix.set;
        in_tlast  <= next_pix.row_end;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------ marking receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap > 0) begin
        out_tready <= 1'b0;
        out_gap    <= out_gap - 1;
      end else if (stall_out && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        out_gap    <= $urandom_range(0, 14);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------ APB access
  task automatic cfg_access(input logic [1:0] idx, input bit wr, input logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wr ? val : '0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (!wr && rd_capture !== val) begin
      $display("%0t: register %0d readback, expected %0d, got %0d",
               $time, idx, val, rd_capture);
      fails++;
    end
  endtask

  task automatic read_back_all();
    cfg_access(REG_LEFT_BOUNDARY, 1'b0, 32'(left_bnd));
    cfg_access(REG_CENTER_BOUNDARY, 1'b0, 32'(center_bnd));
    cfg_access(REG_RIGHT_RUN_LIMIT, 1'b0, 32'(run_limit));
  endtask

  task automatic set_regs(input int lb, input int cb, input int rl);
    cfg_access(REG_LEFT_BOUNDARY, 1'b1, 32'(lb));
    left_bnd = CB'(lb);
    cfg_access(REG_CENTER_BOUNDARY, 1'b1, 32'(cb));
    center_bnd = CB'(cb);
    cfg_access(REG_RIGHT_RUN_LIMIT, 1'b1, 32'(rl));
    run_limit = (CB+1)'(rl);
    settings++;
    read_back_all();
  endtask

  // Wait until every queued pixel went in and every marking came out, then
  // wait out the LAT_PAD padding in case the last pixel caused nothing.
  task automatic drain();
    int waited;
    waited = 0;
    while ((pix_q.size() > 0 || in_tvalid || marking_q.size() > 0) && waited < DRAIN_CAP) begin
      @(posedge clk);
      waited++;
    end
    if (marking_q.size() > 0 || pix_q.size() > 0) begin
      $display("%0t: drain stuck, expected no pending markings, got %0d still owed",
               $time, marking_q.size());
      fails += marking_q.size() + 1;
      marking_q.delete();
    end
    repeat (LAT_PAD) @(posedge clk);
  endtask

  // ------------------------------------------------------------- stimulus
  task automatic pix(input bit s, input int c, input int r, input bit e);
    pixel_t p;
    p = '{s, CB'(c), CB'(r), e};
    pix_q.insert(pix_q.size(), p);
  endtask

  // One scan row of alternating gaps and runs; may wrap past column 1023.
  task automatic add_row(input int width, input int max_run, input bit with_end);
    int            n;
    int            seg;
    bit            on;
    logic [CB-1:0] col;
    logic [CB-1:0] row;
    col = CB'($urandom_range(0, 1023));
    row = CB'($urandom_range(0, 1023));
    on  = 1'($urandom_range(0, 1));
    n   = 0;
    while (n < width) begin
      seg = on ? $urandom_range(1, max_run) : $urandom_range(1, 8);
      repeat (seg) begin
        if (n < width) begin
          pix(on, col, row, with_end && n == width - 1);
          col = col + 1'b1;
          n++;
        end
      end
      on = !on;
    end
  endtask

  task automatic random_phase(input int items);
    int start;
    int pick;
    start = pix_q.size();
    while (pix_q.size() - start < items) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // noise: every field random
        pix(1'($urandom_range(0, 1)), $urandom_range(0, 1023), $urandom_range(0, 1023),
            1'($urandom_range(0, 1)));
      end else if (pick == 1) begin
        add_row($urandom_range(2, 20), 10, 1'b0);   // row cut short, no row end
      end else if (pick == 2) begin
        add_row($urandom_range(60, 140), 120, 1'b1); // long runs for the length limit
      end else begin
        add_row($urandom_range(4, 30), 12, 1'b1);
      end
    end
    drain();
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    stall_in  = 1'b1;
    stall_out = 1'b1;

    // reset values, then directed rows at reset settings
    read_back_all();
    pix(1, 0, 0, 0); pix(1, 1, 0, 0); pix(0, 2, 0, 0);       // left run at column 0
    pix(1, 114, 1, 0); pix(1, 115, 1, 0); pix(1, 116, 1, 1); // mean on left boundary, row end joins
    pix(1, 200, 2, 0); pix(1, 202, 2, 0);                    // column jump breaks run
    pix(1, 203, 3, 0);                                       // row change breaks run
    pix(1, 500, 3, 1);                                       // two runs end, new one dropped
    pix(0, 1023, 1023, 1);                                   // clear row end, nothing open
    drain();

    // both boundaries at zero, limit 2: only single-pixel runs survive
    set_regs(0, 0, 2);
    pix(1, 1022, 1023, 0); pix(1, 1023, 1023, 0);
    pix(1, 0, 1023, 1);                                      // wrap breaks; old dropped, new kept
    pix(1, 1023, 5, 1);
    pix(1, 10, 6, 0); pix(0, 11, 6, 0);
    drain();

    // both boundaries at the top, limit 1024
    set_regs(1023, 1023, 1024);
    pix(1, 1022, 7, 0); pix(1, 1023, 7, 1);
    pix(1, 1023, 8, 1);
    drain();

    // random part; each phase overshoots its target by part of a row
    set_regs(LEFT_BOUNDARY_RST, CENTER_BOUNDARY_RST, RIGHT_RUN_LIMIT_RST);
    random_phase(100);
    set_regs(300, 700, 40);
    stall_out = 1'b0;
    random_phase(95);
    set_regs(0, 1023, 1024);
    stall_out = 1'b1;
    stall_in  = 1'b0;
    random_phase(95);
    set_regs(512, 100, 5);
    stall_in = 1'b1;
    random_phase(95);
    set_regs($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1024));
    random_phase(100);
    // closing stretch at full rate
    set_regs(LEFT_BOUNDARY_RST, CENTER_BOUNDARY_RST, RIGHT_RUN_LIMIT_RST);
    stall_in  = 1'b0;
    stall_out = 1'b0;
    random_phase(100);

    $display("Ran %0d pixel beats under %0d register settings.", beats_in, settings);
    $display("Markings checked: %0d left, %0d center, %0d right; %0d errors.",
             side_seen[0], side_seen[1], side_seen[2], fails);
    if (fails == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Run timed out.");
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lrcc_pkg.sv
src/lrcc_classifier.sv
src/lrcc_run_tracker.sv
src/lane_run_centroid_classifier_core.sv
test/lane_run_centroid_classifier_core_tb.sv
